FILE: rtl/scpa_pkg.sv
`default_nettype none

package scpa_pkg;

    localparam int NUM_CLASSES   = 10;
    localparam int TOTAL_CHUNKS  = 1024;
    localparam int MIN_LOG_SIZE  = 5;
    localparam int LOG_TABLE_LEN = 20;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam int STAT_W = 3;
    localparam int CLS_W  = 4;
    localparam int IDX_W  = 9;   // chunk index within a class
    localparam int CNT_W  = 10;  // free count, holds the largest class size
    localparam int LG_W   = 6;   // rounded log2 of a 32-bit size
    localparam int LT_W   = $clog2(LOG_TABLE_LEN);
    localparam int OFF_W  = 10;  // ring offset of a class
    localparam int POS_W  = 13;  // ring slot before the range check

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_BIG   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CHUNK  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] chunk_address;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_address;
        logic [CLS_W-1:0]  size_class;
    } t_rsp;

    typedef logic [NUM_CLASSES-1:0][OFF_W-1:0] t_off_tab;
    typedef logic [NUM_CLASSES:0][ADDR_W-1:0]  t_start_tab;

    // log2 of the chunk size of each class
    function automatic logic [LG_W-1:0] class_log(input logic [CLS_W-1:0] c);
        case (c)
            4'd0:    return 6'd6;
            4'd1:    return 6'd7;
            4'd2:    return 6'd9;
            4'd3:    return 6'd12;
            4'd4:    return 6'd16;
            4'd5:    return 6'd19;
            4'd6:    return 6'd21;
            4'd7:    return 6'd22;
            4'd8:    return 6'd23;
            4'd9:    return 6'd24;
            default: return 6'd0;
        endcase
    endfunction

    // chunks per class, all powers of two
    function automatic logic [CNT_W-1:0] class_chunks(input logic [CLS_W-1:0] c);
        case (c)
            4'd0:    return 10'd64;
            4'd1:    return 10'd64;
            4'd2:    return 10'd64;
            4'd3:    return 10'd32;
            4'd4:    return 10'd64;
            4'd5:    return 10'd512;
            4'd6:    return 10'd8;
            4'd7:    return 10'd4;
            4'd8:    return 10'd2;
            4'd9:    return 10'd2;
            default: return 10'd0;
        endcase
    endfunction

    // entry i serves rounded log MIN_LOG_SIZE + i
    function automatic logic [CLS_W-1:0] log_to_class(input logic [LT_W-1:0] i);
        case (i)
            5'd0, 5'd1:                return 4'd0;
            5'd2:                      return 4'd1;
            5'd3, 5'd4:                return 4'd2;
            5'd5, 5'd6, 5'd7:          return 4'd3;
            5'd8, 5'd9, 5'd10, 5'd11:  return 4'd4;
            5'd12, 5'd13, 5'd14:       return 4'd5;
            5'd15, 5'd16:              return 4'd6;
            5'd17:                     return 4'd7;
            5'd18:                     return 4'd8;
            5'd19:                     return 4'd9;
            default:                   return 4'd0;
        endcase
    endfunction

    function automatic t_off_tab calc_ring_off();
        t_off_tab tab;
        int       off;
        off = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            tab[c] = OFF_W'(off);
            off    = off + int'(class_chunks(CLS_W'(c)));
        end
        return tab;
    endfunction

    // entry c is the byte offset of class c; the last entry is the region size
    function automatic t_start_tab calc_class_start();
        t_start_tab       tab;
        logic [ADDR_W-1:0] s;
        s = '0;
        for (int c = 0; c <= NUM_CLASSES; c++) begin
            tab[c] = s;
            if (c < NUM_CLASSES) begin
                s = s + (ADDR_W'(class_chunks(CLS_W'(c))) << class_log(CLS_W'(c)));
            end
        end
        return tab;
    endfunction

    localparam t_off_tab   RING_OFF    = calc_ring_off();
    localparam t_start_tab CLASS_START = calc_class_start();

endpackage

`default_nettype wire

FILE: rtl/scpa_ram.sv
`default_nettype none

module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/size_class_pool_allocator_core.sv
`default_nettype none

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+---------------------------------
// cfg      | in        | i_cfg_wr_en              | i_cfg_wr_data (base address)
// request  | in        | i_in_valid / o_in_stall  | i_in_data (t_req)
// response | out       | o_out_valid / i_out_stall| o_out_data (t_rsp)
//
// One transaction in flight. An allocate steps through decode, class lookup, RAM
// access, read-back with write-back, base add and hand-off; a free adds the chunk
// index step before the RAM access and skips the base add. Requests rejected on
// size or address range, and an allocate from an empty class, skip to hand-off.
// The path is set by the read-modify-write of the free ring and busy-bit RAMs
// (registered read) plus the size/address decode stages in front. After reset a
// sweep of all CHUNK_SLOTS slots (1024 by default) fills each class's ring part
// with ascending indices, clears the busy bits and holds o_in_stall high. The result
// sits in an output register, so a new request is taken while a finished response is stalled.

module size_class_pool_allocator_core
    import scpa_pkg::*;
#(
    parameter int CHUNK_SLOTS = TOTAL_CHUNKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_data
);

    localparam int AW = $clog2(CHUNK_SLOTS);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;  // post-reset RAM sweep
    localparam logic [3:0] S_IDLE = 4'd1;  // ready for a transaction
    localparam logic [3:0] S_DEC  = 4'd2;  // size log2 / address minus base
    localparam logic [3:0] S_CLS  = 4'd3;  // class lookup
    localparam logic [3:0] S_IDX  = 4'd4;  // free: chunk index within class
    localparam logic [3:0] S_ACC  = 4'd5;  // issue RAM read; allocate updates head/count
    localparam logic [3:0] S_RD   = 4'd6;  // RAM data back, write back; free updates count
    localparam logic [3:0] S_ADR  = 4'd7;  // allocate: add base
    localparam logic [3:0] S_FIN  = 4'd8;  // hand off to output register

    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_base;
    t_req              r_req;
    logic [LG_W-1:0]   r_lg;
    logic [ADDR_W-1:0] r_rel;
    logic              r_under;
    logic [CLS_W-1:0]  r_cls;
    logic [IDX_W-1:0]  r_idx;
    logic              r_idx_big;
    logic [AW-1:0]     r_pos;
    logic              r_ring_ok;
    logic [ADDR_W-1:0] r_part;
    logic [STAT_W-1:0] r_status;
    logic [ADDR_W-1:0] r_res_addr;
    logic [CNT_W-1:0]  r_count [NUM_CLASSES];
    logic [IDX_W-1:0]  r_head  [NUM_CLASSES];
    logic [AW-1:0]     r_clr_addr;
    logic [CLS_W-1:0]  r_clr_cls;
    logic [IDX_W-1:0]  r_clr_idx;
    t_rsp              r_out;
    logic              r_out_vld;

    logic              in_acc;
    logic              out_free;
    logic              is_alloc;
    logic [SIZE_W-1:0] size_m1;
    logic [LG_W-1:0]   lg_raw, lg;
    logic [ADDR_W:0]   rel_full;
    logic [LG_W-1:0]   lg_off;
    logic              too_big;
    logic [CLS_W-1:0]  cls_alloc, cls_free;
    logic              found;
    logic [ADDR_W-1:0] diff, shifted;
    logic [CNT_W-1:0]  cur_chunks, cur_chunks_m1;
    logic [IDX_W-1:0]  chunk_mask;
    logic [LG_W-1:0]   cur_log;
    logic [IDX_W-1:0]  cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic              cnt_zero;
    logic [POS_W-1:0]  acc_pos;
    logic              acc_pos_ok;
    logic [IDX_W-1:0]  ring_rdata, ring_idx;
    logic              busy_rdata;
    logic [POS_W-1:0]  bpos;
    logic              bpos_ok;
    logic [CNT_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail;
    logic [POS_W-1:0]  tpos;
    logic              tpos_ok;
    logic              free_ok;
    logic [CNT_W-1:0]  clr_chunks_m1;
    logic [IDX_W-1:0]  clr_data;
    logic              clr_in_class;

    logic              ring_we, ring_re;
    logic [AW-1:0]     ring_waddr;
    logic [IDX_W-1:0]  ring_wdata;
    logic              busy_we, busy_re, busy_wdata;
    logic [AW-1:0]     busy_waddr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign is_alloc = (r_req.func == FUNC_ALLOC);

    // ---- decode: ceil log2 of the size, clamped from below to MIN_LOG_SIZE
    assign size_m1 = r_req.request_size - 1'b1;

    always_comb begin
        lg_raw = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                lg_raw = LG_W'(i + 1);
            end
        end
        // sizes 0 and 1 round to 2^0
        if (r_req.request_size <= SIZE_W'(1)) begin
            lg_raw = '0;
        end
        lg = (lg_raw < LG_W'(MIN_LOG_SIZE)) ? LG_W'(MIN_LOG_SIZE) : lg_raw;
    end

    // borrow out of the subtract flags an address below the base
    assign rel_full = {1'b0, r_req.chunk_address} - {1'b0, r_base};

    // ---- class lookup
    assign lg_off    = r_lg - LG_W'(MIN_LOG_SIZE);
    assign too_big   = (lg_off >= LG_W'(LOG_TABLE_LEN));
    assign cls_alloc = log_to_class(lg_off[LT_W-1:0]);

    // first class whose end lies strictly above the relative address
    always_comb begin
        found    = 1'b0;
        cls_free = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_rel < CLASS_START[c+1]) begin
                found    = 1'b1;
                cls_free = CLS_W'(c);
            end
        end
    end

    // ---- per-class values for the selected class
    assign cur_chunks    = class_chunks(r_cls);
    assign cur_chunks_m1 = cur_chunks - 1'b1;
    assign chunk_mask    = cur_chunks_m1[IDX_W-1:0];  // class sizes are powers of two
    assign cur_log       = class_log(r_cls);
    assign cur_head      = r_head[r_cls];
    assign cur_count     = r_count[r_cls];
    assign cnt_zero      = (cur_count == '0);

    // free: index of the chunk holding the address
    assign diff    = r_rel - CLASS_START[r_cls];
    assign shifted = diff >> cur_log;

    // allocate reads the ring at the head, free reads the busy bit of its chunk
    assign acc_pos    = POS_W'(RING_OFF[r_cls]) + POS_W'(is_alloc ? cur_head : r_idx);
    assign acc_pos_ok = (acc_pos < POS_W'(CHUNK_SLOTS));

    // allocate write-back: busy bit of the chunk handed out
    assign ring_idx = (r_ring_ok ? ring_rdata : '0) & chunk_mask;
    assign bpos     = POS_W'(RING_OFF[r_cls]) + POS_W'(ring_idx);
    assign bpos_ok  = (bpos < POS_W'(CHUNK_SLOTS));

    // free write-back: ring tail of the class
    assign tail_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
    assign tail     = tail_sum[IDX_W-1:0] & chunk_mask;
    assign tpos     = POS_W'(RING_OFF[r_cls]) + POS_W'(tail);
    assign tpos_ok  = (tpos < POS_W'(CHUNK_SLOTS));
    assign free_ok  = (r_state == S_RD) && !is_alloc && busy_rdata;

    // ---- sweep: slot within its class, zero past the last class
    assign clr_in_class  = (r_clr_cls < CLS_W'(NUM_CLASSES));
    assign clr_chunks_m1 = class_chunks(r_clr_cls) - 1'b1;
    assign clr_data      = clr_in_class ? r_clr_idx : '0;

    // ---- RAM ports
    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = tpos[AW-1:0];
        ring_wdata = r_idx;
        ring_re    = (r_state == S_ACC) && is_alloc && !cnt_zero && acc_pos_ok;
        busy_we    = 1'b0;
        busy_waddr = r_pos;
        busy_wdata = 1'b0;
        busy_re    = (r_state == S_ACC) && !is_alloc && !r_idx_big && acc_pos_ok;
        if (r_state == S_CLR) begin
            ring_we    = 1'b1;
            ring_waddr = r_clr_addr;
            ring_wdata = clr_data;
            busy_we    = 1'b1;
            busy_waddr = r_clr_addr;
        end else if (r_state == S_RD) begin
            if (is_alloc) begin
                busy_we    = bpos_ok;
                busy_waddr = bpos[AW-1:0];
                busy_wdata = 1'b1;
            end else begin
                busy_we = busy_rdata;
                ring_we = busy_rdata && tpos_ok;
            end
        end
    end

    scpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CHUNK_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (acc_pos[AW-1:0]),
        .o_rdata (ring_rdata)
    );

    scpa_ram #(
        .WIDTH (1),
        .DEPTH (CHUNK_SLOTS)
    ) u_busy (
        .i_clk   (i_clk),
        .i_we    (busy_we),
        .i_waddr (busy_waddr),
        .i_wdata (busy_wdata),
        .i_re    (busy_re),
        .i_raddr (acc_pos[AW-1:0]),
        .o_rdata (busy_rdata)
    );

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr_addr == AW'(CHUNK_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: if (in_acc) n_state = S_DEC;
            S_DEC:  n_state = S_CLS;
            S_CLS: begin
                if (is_alloc) begin
                    n_state = too_big ? S_FIN : S_ACC;
                end else begin
                    n_state = (r_under || !found) ? S_FIN : S_IDX;
                end
            end
            S_IDX:  n_state = S_ACC;
            S_ACC: begin
                if (is_alloc) begin
                    n_state = cnt_zero ? S_FIN : S_RD;
                end else begin
                    n_state = (r_idx_big || !acc_pos_ok) ? S_FIN : S_RD;
                end
            end
            S_RD:   n_state = is_alloc ? S_ADR : S_FIN;
            S_ADR:  n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_cls  <= '0;
            r_clr_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (clr_in_class) begin
                    if (r_clr_idx == clr_chunks_m1[IDX_W-1:0]) begin
                        r_clr_cls <= r_clr_cls + 1'b1;
                        r_clr_idx <= '0;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    // free ring head and free count per class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= class_chunks(CLS_W'(c));
                r_head[c]  <= '0;
            end
        end else if ((r_state == S_ACC) && is_alloc && !cnt_zero) begin
            r_head[r_cls]  <= (cur_head + 1'b1) & chunk_mask;
            r_count[r_cls] <= cur_count - 1'b1;
        end else if (free_ok && (cur_count < cur_chunks)) begin
            r_count[r_cls] <= cur_count + 1'b1;
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req      <= i_in_data;
                r_res_addr <= '0;
                r_status   <= ST_OK;
            end
            S_DEC: begin
                r_lg    <= lg;
                r_rel   <= rel_full[ADDR_W-1:0];
                r_under <= rel_full[ADDR_W];
            end
            S_CLS: begin
                if (is_alloc) begin
                    r_cls    <= too_big ? '0 : cls_alloc;
                    r_status <= too_big ? ST_TOO_BIG : ST_OK;
                end else begin
                    r_cls    <= (r_under || !found) ? '0 : cls_free;
                    r_status <= (r_under || !found) ? ST_BAD_ADDR : ST_OK;
                end
            end
            S_IDX: begin
                r_idx     <= shifted[IDX_W-1:0];
                r_idx_big <= (shifted >= ADDR_W'(cur_chunks));
            end
            S_ACC: begin
                r_pos     <= acc_pos[AW-1:0];
                r_ring_ok <= acc_pos_ok;
                if (is_alloc) begin
                    if (cnt_zero) r_status <= ST_NO_CHUNK;
                end else if (r_idx_big) begin
                    r_status <= ST_BAD_ADDR;
                    r_cls    <= '0;
                end else if (!acc_pos_ok) begin
                    r_status <= ST_NOT_ALLOC;
                end
            end
            S_RD: begin
                r_part <= CLASS_START[r_cls] + (ADDR_W'(ring_idx) << cur_log);
                if (!is_alloc && !busy_rdata) r_status <= ST_NOT_ALLOC;
            end
            S_ADR: begin
                r_res_addr <= r_base + r_part;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out.status         <= r_status;
            r_out.result_address <= r_res_addr;
            r_out.size_class     <= r_cls;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_accept_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DEC))
        else $error("accepted transaction did not enter decode");

    a_fin_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished transaction not handed to output register");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (cur_count <= cur_chunks))
        else $error("free count above class size");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ((cur_head & ~chunk_mask) == '0))
        else $error("ring head outside its class");
`endif

endmodule

`default_nettype wire
